@@ src/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// Shared widths, command and status codes, and helpers for the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 8;
	localparam int FUNC_W    = 3;
	localparam int STAT_W    = 2;
	localparam int LEN_W     = 7;

	localparam logic [FUNC_W-1:0] FN_READ     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_INS_AT   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd4;

	localparam logic [VAL_W-1:0] READ_MISS = {VAL_W{1'b1}};

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_ctrl_t;

	typedef struct packed {
		logic             rd_miss;
		status_t          status;
		logic [LEN_W-1:0] length;
	} side_t;

	// levels of a radix-4 reduction tree over n leaves
	function automatic int tree_levels(input int n);
		int span;
		int lv;
		span = 4;
		lv   = 1;
		for (int i = 0; i < 8; i++) begin
			if (span < n) begin
				span = span * 4;
				lv   = lv + 1;
			end
		end
		return lv;
	endfunction

	// node count at a given tree level over n leaves
	function automatic int tree_nodes(input int n, input int level);
		int cnt;
		cnt = n;
		for (int i = 0; i < 8; i++) begin
			if (i <= level) begin
				cnt = (cnt + 3) / 4;
			end
		end
		return cnt;
	endfunction

endpackage

`default_nettype wire

@@ src/ile_cell.sv @@
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds, takes its left or right neighbor, or loads the value.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell #(
	parameter int AW  = 7,
	parameter int IDX = 0
) (
	input  wire logic                     clk,
	input  wire ile_pkg::cell_ctrl_t      ctrl,
	input  wire logic [AW-1:0]            addr,
	input  wire logic [ile_pkg::VAL_W-1:0] item_value,
	input  wire logic [ile_pkg::VAL_W-1:0] left,
	input  wire logic [ile_pkg::VAL_W-1:0] right,
	output logic      [ile_pkg::VAL_W-1:0] value,
	output logic      [ile_pkg::VAL_W-1:0] sel_value
);

	localparam logic [AW-1:0] IDXA = AW'(IDX);

	logic [ile_pkg::VAL_W-1:0] value_q;
	logic [ile_pkg::VAL_W-1:0] value_nxt;

	always_comb begin
		if (ctrl.ins && (IDXA > addr)) begin
			value_nxt = left;
		end else if (ctrl.ins && (IDXA == addr)) begin
			value_nxt = item_value;
		end else if (ctrl.del && (IDXA >= addr)) begin
			value_nxt = right;
		end else begin
			value_nxt = value_q;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

	assign value     = value_q;
	assign sel_value = (ctrl.rd && (IDXA == addr)) ? value_q : '0;

endmodule

`default_nettype wire

@@ src/ile_read_tree.sv @@
// ----------------------------------------------------------------------------
// ile_read_tree
// Registered radix-4 OR tree over the cell read taps, with a sideband lane.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_read_tree #(
	parameter int N      = 64,
	parameter int WIDTH  = 32,
	parameter int SIDE_W = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [WIDTH-1:0]  leaf [N],
	input  wire logic              in_valid,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic      [WIDTH-1:0]  out_data,
	output logic      [SIDE_W-1:0] out_side
);

	localparam int LEVELS = ile_pkg::tree_levels(N);
	localparam int NODES0 = ile_pkg::tree_nodes(N, 0);

	logic [WIDTH-1:0]  node_q [LEVELS][NODES0];
	logic [SIDE_W-1:0] side_q [LEVELS];
	logic              vld_q  [LEVELS];

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		localparam int CNT  = ile_pkg::tree_nodes(N, l);
		localparam int PREV = (l == 0) ? N : ile_pkg::tree_nodes(N, l - 1);
		for (genvar j = 0; j < NODES0; j++) begin : g_node
			if (j < CNT) begin : g_used
				logic [WIDTH-1:0] kid [4];
				for (genvar c = 0; c < 4; c++) begin : g_kid
					if (4 * j + c >= PREV) begin : g_pad
						assign kid[c] = '0;
					end else if (l == 0) begin : g_leaf
						assign kid[c] = leaf[4 * j + c];
					end else begin : g_inner
						assign kid[c] = node_q[l - 1][4 * j + c];
					end
				end
				always_ff @(posedge clk) begin
					node_q[l][j] <= kid[0] | kid[1] | kid[2] | kid[3];
				end
			end else begin : g_unused
				always_ff @(posedge clk) begin
					node_q[l][j] <= '0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[l] <= 1'b0;
			end else if (l == 0) begin
				vld_q[l] <= in_valid;
			end else begin
				vld_q[l] <= vld_q[(l == 0) ? 0 : l - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (l == 0) begin
				side_q[l] <= in_side;
			end else begin
				side_q[l] <= side_q[(l == 0) ? 0 : l - 1];
			end
		end
	end

	assign out_valid = vld_q[LEVELS-1];
	assign out_data  = node_q[LEVELS-1][0];
	assign out_side  = side_q[LEVELS-1];

endmodule

`default_nettype wire

@@ src/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed values in a row of shifting cells, with indexed
// read, insert and delete commands.
// ----------------------------------------------------------------------------
// Results pass through the registered OR tree that collects the read tap
// from the cells; status and length ride along in its sideband lane.
// Throughput: one command per cycle; cells shift in parallel at accept.
// Reset clears the entry count and the result pipeline; cell contents are
// undefined until written. The receiver cannot stall: done is a strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic        [ile_pkg::FUNC_W-1:0] func,
	input  wire logic        [ile_pkg::POS_W-1:0]  position,
	input  wire logic signed [ile_pkg::VAL_W-1:0]  item_value,
	output logic                                  done,
	output logic signed      [ile_pkg::VAL_W-1:0]  read_value,
	output logic             [ile_pkg::STAT_W-1:0] status,
	output logic             [ile_pkg::LEN_W-1:0]  length
);

	localparam int CW     = $clog2(DEPTH + 1);
	localparam int CMPW   = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
	localparam int LENX   = (CW > ile_pkg::LEN_W) ? CW : ile_pkg::LEN_W;
	localparam int SIDE_W = $bits(ile_pkg::side_t);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nxt;
	logic [CW-1:0]        addr;
	logic [CMPW-1:0]      pos_x;
	logic [CMPW-1:0]      cnt_x;
	logic                 accept;
	logic                 want_ins;
	logic                 rd_miss;
	ile_pkg::status_t     st_c;
	ile_pkg::cell_ctrl_t  ctrl_c;
	ile_pkg::cell_ctrl_t  ctrl;
	ile_pkg::side_t       side_c;
	ile_pkg::side_t       side_out;
	logic [SIDE_W-1:0]    side_bits;
	logic [LENX-1:0]      len_x;
	logic                 tree_valid;
	logic [ile_pkg::VAL_W-1:0] tree_data;
	logic [ile_pkg::VAL_W-1:0] cell_val [DEPTH];
	logic [ile_pkg::VAL_W-1:0] sel_val  [DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pos_x  = CMPW'(position);
	assign cnt_x  = CMPW'(count_q);

	// decode command against the current count
	always_comb begin
		ctrl_c    = '0;
		want_ins  = 1'b0;
		rd_miss   = 1'b0;
		addr      = pos_x[CW-1:0];
		st_c      = ile_pkg::ST_DONE;
		count_nxt = count_q;
		unique case (func)
			ile_pkg::FN_READ: begin
				if (pos_x < cnt_x) begin
					ctrl_c.rd = 1'b1;
				end else begin
					rd_miss = 1'b1;
					st_c    = ile_pkg::ST_INVALID;
				end
			end
			ile_pkg::FN_INS_HEAD: begin
				addr     = '0;
				want_ins = 1'b1;
			end
			ile_pkg::FN_INS_TAIL: begin
				addr     = count_q;
				want_ins = 1'b1;
			end
			ile_pkg::FN_INS_AT: begin
				if (pos_x > cnt_x) begin
					st_c = ile_pkg::ST_INVALID;
				end else begin
					want_ins = 1'b1;
				end
			end
			ile_pkg::FN_DELETE: begin
				if (pos_x >= cnt_x) begin
					st_c = ile_pkg::ST_INVALID;
				end else begin
					ctrl_c.del = 1'b1;
					count_nxt  = count_q - 1'b1;
				end
			end
			default: begin
				st_c = ile_pkg::ST_INVALID;
			end
		endcase
		if (want_ins) begin
			if (count_q == FULL_CNT) begin
				st_c = ile_pkg::ST_FULL;
			end else begin
				ctrl_c.ins = 1'b1;
				count_nxt  = count_q + 1'b1;
			end
		end
	end

	assign ctrl.ins = ctrl_c.ins && accept;
	assign ctrl.del = ctrl_c.del && accept;
	assign ctrl.rd  = ctrl_c.rd && accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	assign len_x          = LENX'(count_nxt);
	assign side_c.rd_miss = rd_miss;
	assign side_c.status  = st_c;
	assign side_c.length  = len_x[ile_pkg::LEN_W-1:0];

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [ile_pkg::VAL_W-1:0] left_w;
		logic [ile_pkg::VAL_W-1:0] right_w;
		if (k == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_val[k - 1];
		end
		if (k == DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_val[k + 1];
		end
		ile_cell #(
			.AW  (CW),
			.IDX (k)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.addr       (addr),
			.item_value (item_value),
			.left       (left_w),
			.right      (right_w),
			.value      (cell_val[k]),
			.sel_value  (sel_val[k])
		);
	end

	ile_read_tree #(
		.N      (DEPTH),
		.WIDTH  (ile_pkg::VAL_W),
		.SIDE_W (SIDE_W)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.leaf      (sel_val),
		.in_valid  (accept),
		.in_side   (side_c),
		.out_valid (tree_valid),
		.out_data  (tree_data),
		.out_side  (side_bits)
	);

	assign side_out   = ile_pkg::side_t'(side_bits);
	assign done       = tree_valid;
	assign read_value = side_out.rd_miss ? ile_pkg::READ_MISS : tree_data;
	assign status     = side_out.status;
	assign length     = side_out.length;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st_c == ile_pkg::ST_FULL) |=> (count_q == $past(count_q)))
		else $error("count moved on dropped insert");

	a_miss_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && side_out.rd_miss) |-> (status == ile_pkg::ST_INVALID))
		else $error("read miss without invalid status");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.ins, ctrl.del, ctrl.rd}))
		else $error("more than one cell operation");

endmodule

`default_nettype wire

@@ verif/indexed_list_checker.sv @@
// ----------------------------------------------------------------------------
// indexed_list_checker
// Watches the command and result ports of the list engine, keeps its own
// copy of the list, works out the reply to every accepted command and
// compares each done beat field by field with the oldest reply still due.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_checker #(
	parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic                             busy,
	input  wire logic        [ile_pkg::FUNC_W-1:0] func,
	input  wire logic        [ile_pkg::POS_W-1:0]  position,
	input  wire logic signed [ile_pkg::VAL_W-1:0]  item_value,
	input  wire logic                             done,
	input  wire logic signed [ile_pkg::VAL_W-1:0]  read_value,
	input  wire logic        [ile_pkg::STAT_W-1:0] status,
	input  wire logic        [ile_pkg::LEN_W-1:0]  length,
	output int                                    mismatches,
	output int                                    outstanding
);

	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic [ile_pkg::VAL_W-1:0] value;
		ile_pkg::status_t          code;
		logic [ile_pkg::LEN_W-1:0] count;
	} list_reply_t;

	list_reply_t               replies_due[$];
	logic [ile_pkg::VAL_W-1:0] cells[DEPTH];
	int                        fill;

	function automatic ile_pkg::status_t place_at(input int at,
			input logic [ile_pkg::VAL_W-1:0] v);
		if (at > fill)
			return ile_pkg::ST_INVALID;
		if (fill >= DEPTH)
			return ile_pkg::ST_FULL;
		for (int k = fill; k > at; k--)
			cells[k] = cells[k - 1];
		cells[at] = v;
		fill++;
		return ile_pkg::ST_DONE;
	endfunction

	function automatic list_reply_t run_list_cmd(input logic [ile_pkg::FUNC_W-1:0] f,
			input logic [ile_pkg::POS_W-1:0] p, input logic [ile_pkg::VAL_W-1:0] v);
		list_reply_t r;
		r.value = '0;
		case (f)
			ile_pkg::FN_READ: begin
				if (int'(p) < fill) begin
					r.value = cells[p];
					r.code  = ile_pkg::ST_DONE;
				end else begin
					r.value = ile_pkg::READ_MISS;
					r.code  = ile_pkg::ST_INVALID;
				end
			end
			ile_pkg::FN_INS_HEAD: r.code = place_at(0, v);
			ile_pkg::FN_INS_TAIL: r.code = place_at(fill, v);
			ile_pkg::FN_INS_AT:   r.code = place_at(int'(p), v);
			ile_pkg::FN_DELETE: begin
				if (int'(p) >= fill) begin
					r.code = ile_pkg::ST_INVALID;
				end else begin
					for (int k = int'(p); k + 1 < fill; k++)
						cells[k] = cells[k + 1];
					fill--;
					r.code = ile_pkg::ST_DONE;
				end
			end
			default: r.code = ile_pkg::ST_INVALID;
		endcase
		r.count = fill[ile_pkg::LEN_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t due;
		if (!arst_n) begin
			fill = 0;
			replies_due.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("unexpected result beat: read_value %h status %0d length %0d",
							read_value, status, length);
				end else begin
					due = replies_due.pop_front();
					if (read_value !== due.value || status !== due.code ||
							length !== due.count) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT)
							$display({"result mismatch: read_value exp %h got %h, ",
								"status exp %0d got %0d, length exp %0d got %0d"},
								due.value, read_value, due.code, status,
								due.count, length);
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(run_list_cmd(func, position, item_value));
			outstanding = replies_due.size();
		end
	end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the list engine with a directed command set, then with random
// commands shaped to fill, churn and drain the list, under several sender
// idling phases. The checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int FUNC_W = ile_pkg::FUNC_W;
	localparam int POS_W  = ile_pkg::POS_W;
	localparam int VAL_W  = ile_pkg::VAL_W;
	localparam int STAT_W = ile_pkg::STAT_W;
	localparam int LEN_W  = ile_pkg::LEN_W;

	localparam int LIST_DEPTH   = ile_pkg::DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

	localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7fff_ffff;
	localparam logic [VAL_W-1:0] VAL_ONES = 32'hffff_ffff;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic        [FUNC_W-1:0] func = '0;
	logic        [POS_W-1:0]  position = '0;
	logic signed [VAL_W-1:0]  item_value = '0;
	wire logic                busy;
	wire logic                done;
	wire logic signed [VAL_W-1:0] read_value;
	wire logic [STAT_W-1:0]   status;
	wire logic [LEN_W-1:0]    length;

	logic took;
	int   quiet_cycles = 0;
	int   idle_pct = 0;
	int   fill_guess = 0;
	int   mismatches;
	int   outstanding;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	indexed_list_engine #(.DEPTH(LIST_DEPTH)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.position   (position),
		.item_value (item_value),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.length     (length)
	);

	indexed_list_checker #(.DEPTH(LIST_DEPTH)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.position    (position),
		.item_value  (item_value),
		.done        (done),
		.read_value  (read_value),
		.status      (status),
		.length      (length),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			took <= 1'b0;
		else
			took <= start && !busy;
	end

	always @(posedge clk) begin
		if (took || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// drive one command beat and hold it until accepted
	task automatic issue_cmd(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic [VAL_W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start      = 1'b1;
		func       = f;
		position   = p;
		item_value = v;
		@(negedge clk);
		while (!took)
			@(negedge clk);
		case (f) inside
			ile_pkg::FN_INS_HEAD, ile_pkg::FN_INS_TAIL: begin
				if (fill_guess < LIST_DEPTH) fill_guess++;
			end
			ile_pkg::FN_INS_AT: begin
				if (int'(p) <= fill_guess && fill_guess < LIST_DEPTH) fill_guess++;
			end
			ile_pkg::FN_DELETE: begin
				if (int'(p) < fill_guess) fill_guess--;
			end
			default: ;
		endcase
	endtask

	task automatic hold_until_drained();
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return VAL_ONES;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int                r;
		int                bias;
		logic [FUNC_W-1:0] f;
		logic [POS_W-1:0]  p;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list corner cases
		issue_cmd(ile_pkg::FN_READ,   8'd0, VAL_ONES);
		issue_cmd(ile_pkg::FN_DELETE, 8'd0, '0);
		issue_cmd(ile_pkg::FN_INS_AT, 8'd1, VAL_MAX);
		// build a short list with extreme values
		issue_cmd(ile_pkg::FN_INS_AT,   8'd0, VAL_MIN);
		issue_cmd(ile_pkg::FN_INS_HEAD, 8'd255, VAL_MAX);
		issue_cmd(ile_pkg::FN_INS_TAIL, 8'd255, VAL_ONES);
		issue_cmd(ile_pkg::FN_INS_AT,   8'd3, '0);
		issue_cmd(ile_pkg::FN_INS_AT,   8'd1, 32'h5555_aaaa);
		for (int i = 0; i < 5; i++)
			issue_cmd(ile_pkg::FN_READ, POS_W'(i), '0);
		issue_cmd(ile_pkg::FN_READ,   8'd5, '0);
		issue_cmd(ile_pkg::FN_READ,   8'd255, '0);
		issue_cmd(ile_pkg::FN_DELETE, 8'd255, '0);
		issue_cmd(ile_pkg::FN_DELETE, 8'd4, '0);
		issue_cmd(ile_pkg::FN_DELETE, 8'd0, '0);
		for (int s = FN_SPARE_FIRST; s <= FN_SPARE_LAST; s++)
			issue_cmd(FUNC_W'(s), 8'd255, VAL_ONES);
		issue_cmd(ile_pkg::FN_INS_AT, 8'd255, VAL_MIN);
		issue_cmd(ile_pkg::FN_READ,   8'd0, '0);

		hold_until_drained();

		for (int j = 0; j < RANDOM_ITEMS; j++) begin
			case ((j / 75) % 4)
				0: idle_pct = 0;
				1: idle_pct = 72;
				2: idle_pct = 0;
				default: idle_pct = 31;
			endcase
			if (j == RANDOM_ITEMS / 2)
				hold_until_drained();
			bias = (j / 150) % 3;
			if ($urandom_range(0, 99) < 15) begin
				f = FUNC_W'($urandom_range(0, 7));
				p = POS_W'($urandom_range(0, 255));
			end else begin
				r = $urandom_range(0, 99);
				if (r < (bias == 1 ? 30 : 15)) begin
					f = ile_pkg::FN_READ;
				end else if (r < (bias == 0 ? 85 : (bias == 1 ? 65 : 30))) begin
					case ($urandom_range(0, 2))
						0: f = ile_pkg::FN_INS_HEAD;
						1: f = ile_pkg::FN_INS_TAIL;
						default: f = ile_pkg::FN_INS_AT;
					endcase
				end else begin
					f = ile_pkg::FN_DELETE;
				end
				if (f == ile_pkg::FN_INS_AT || fill_guess == 0 || $urandom_range(0, 19) == 0)
					p = POS_W'($urandom_range(0, fill_guess));
				else
					p = POS_W'($urandom_range(0, fill_guess - 1));
			end
			issue_cmd(f, p, pick_value());
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
